>>> sv/rfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfc_pkg
// Shared types and constants for the rail fence cipher block.
// ----------------------------------------------------------------------------
package rfc_pkg;

   localparam int MAX_LEN_DEF = 64;
   localparam int RAIL_W      = 7;
   localparam int BYTE_W      = 8;

   localparam logic [RAIL_W-1:0] RAIL_RESET = RAIL_W'(2);

   // register indexes of the config port
   localparam logic CSR_RAIL_COUNT   = 1'b0;
   localparam logic CSR_DECRYPT_MODE = 1'b1;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_WALK,
      ST_EMIT
   } rfc_state_type;

   typedef struct packed {
      logic issue;
      logic done;
   } walk_ctl_type;

endpackage : rfc_pkg
`default_nettype wire

>>> sv/rfc_walk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfc_walk
// Zigzag address sequencer: steps one shared adder along each rail in turn
// and gives one (message position, rail order index) pair per issue cycle.
// ----------------------------------------------------------------------------
module rfc_walk #(
   parameter int MAX_LEN = rfc_pkg::MAX_LEN_DEF
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  start,
   input  wire [rfc_pkg::RAIL_W-1:0]            rail_count,
   input  wire                                  decrypt_mode,
   input  wire [$clog2(MAX_LEN+1)-1:0]          msg_len,
   output rfc_pkg::walk_ctl_type                walk_ctl,
   output logic [$clog2(MAX_LEN)-1:0]           rd_addr,
   output logic [$clog2(MAX_LEN)-1:0]           wr_addr
);

   localparam int AW = $clog2(MAX_LEN);
   localparam int CW = $clog2(MAX_LEN+1);
   localparam int RW = rfc_pkg::RAIL_W;
   // position can overshoot the message by one full period
   localparam int PW = $clog2(MAX_LEN + 2**(RW+1));

   logic          busy_ff,  busy_in;
   logic [RW-1:0] rail_ff,  rail_in;
   logic [PW-1:0] pos_ff,   pos_in;
   logic          phase_ff, phase_in;
   logic [CW-1:0] k_ff,     k_in;

   logic [PW-1:0] period;
   logic [PW-1:0] two_r;
   logic [PW-1:0] step_a;
   logic [PW-1:0] step_b;
   logic [PW-1:0] step;
   logic [RW:0]   next_rail;
   logic [RW:0]   rails_eff;
   logic          in_range;
   logic          single_rail;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      rail_ff  <= rail_in;
      pos_ff   <= pos_in;
      phase_ff <= phase_in;
      k_ff     <= k_in;
   end

   always_comb begin
      single_rail = (rail_count <= RW'(1));
      rails_eff   = (rail_count == '0) ? (RW+1)'(1) : {1'b0, rail_count};
      period      = PW'({rail_count, 1'b0}) - PW'(2);
      two_r       = PW'({rail_ff, 1'b0});
      step_a      = period - two_r;
      step_b      = two_r;
      // going down toward the turn, then back up; a zero leg means a full period
      step        = phase_ff ? step_b : step_a;
      if (step == '0) begin
         step = phase_ff ? step_a : step_b;
      end
      if (single_rail) begin
         step = PW'(1);
      end
      in_range  = (pos_ff < PW'(msg_len));
      next_rail = {1'b0, rail_ff} + (RW+1)'(1);

      busy_in        = busy_ff;
      rail_in        = rail_ff;
      pos_in         = pos_ff;
      phase_in       = phase_ff;
      k_in           = k_ff;
      walk_ctl.issue = 1'b0;
      walk_ctl.done  = 1'b0;

      if (start) begin
         busy_in  = 1'b1;
         rail_in  = '0;
         pos_in   = '0;
         phase_in = 1'b0;
         k_in     = '0;
      end else if (busy_ff) begin
         if (in_range) begin
            walk_ctl.issue = 1'b1;
            pos_in         = pos_ff + step;
            phase_in       = ~phase_ff;
            k_in           = k_ff + CW'(1);
         end else if ((next_rail >= rails_eff) || (PW'(next_rail) >= PW'(msg_len))) begin
            busy_in       = 1'b0;
            walk_ctl.done = 1'b1;
         end else begin
            rail_in  = next_rail[RW-1:0];
            pos_in   = PW'(next_rail);
            phase_in = 1'b0;
         end
      end

      rd_addr = decrypt_mode ? k_ff[AW-1:0] : pos_ff[AW-1:0];
      wr_addr = decrypt_mode ? pos_ff[AW-1:0] : k_ff[AW-1:0];
   end

endmodule : rfc_walk
`default_nettype wire

>>> sv/rail_fence_cipher.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rail_fence_cipher
// Buffers a message and emits it permuted along the rail fence zigzag.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* carries one message byte per request (tlast marks the final one);
//    bytes load at one per cycle, while req_tready is high, into a
//    MAX_LEN-byte buffer. Bytes past the buffer are dropped and every
//    result of that message carries the overflow flag in rsp_tuser.
//  - csr_* writes rail_count (index 0) or decrypt_mode (index 1); write
//    only while no message is in flight.
//  - after the last request, req_tready drops while the zigzag walk runs;
//    each issuing step does one add on the shared position adder and one
//    buffer read. Then the result buffer drains one byte at a time through
//    a registered memory read and then the output register, each read
//    waiting until the byte before it has left that read; tlast on the final byte.
//  - a stalled rsp_tready holds the output register and pauses the drain.
//  - req_tready returns as soon as the last result sits in the output
//    register, so the next message loads while it waits.
//  - reset clears the byte count, the overflow flag, and sets two rails
//    in encrypt mode; buffer contents are not cleared.
// ----------------------------------------------------------------------------
module rail_fence_cipher #(
   parameter int MAX_LEN = rfc_pkg::MAX_LEN_DEF
) (
   input  wire                         clock,
   input  wire                         reset,
   // request: [7:0] data_byte
   input  wire                         req_tvalid,
   output logic                        req_tready,
   input  wire [rfc_pkg::BYTE_W-1:0]   req_tdata,
   input  wire                         req_tlast,
   // response: [7:0] out_byte
   output logic                        rsp_tvalid,
   input  wire                         rsp_tready,
   output logic [rfc_pkg::BYTE_W-1:0]  rsp_tdata,
   output logic                        rsp_tlast,
   // response user: [0] overflow
   output logic                        rsp_tuser,
   input  wire                         csr_valid,
   output logic                        csr_ready,
   input  wire                         csr_index,
   input  wire [rfc_pkg::RAIL_W-1:0]   csr_data
);

   localparam int AW = $clog2(MAX_LEN);
   localparam int CW = $clog2(MAX_LEN+1);
   localparam int BW = rfc_pkg::BYTE_W;
   localparam int RW = rfc_pkg::RAIL_W;

   rfc_pkg::rfc_state_type state_ff, state_in;

   logic [RW-1:0] rail_count_ff, rail_count_in;
   logic          decrypt_ff,    decrypt_in;
   logic [CW-1:0] count_ff,      count_in;
   logic          ovf_ff,        ovf_in;
   logic [CW-1:0] emit_ff,       emit_in;
   logic          pend_ff,       pend_in;
   logic          pend_last_ff,  pend_last_in;
   logic          wr_en_ff;
   logic [AW-1:0] wr_addr_ff;
   logic          rsp_valid_ff,  rsp_valid_in;
   logic [BW-1:0] rsp_data_ff,   rsp_data_in;
   logic          rsp_last_ff,   rsp_last_in;
   logic          rsp_ovf_ff,    rsp_ovf_in;

   logic [BW-1:0] msg_mem [MAX_LEN];
   logic [BW-1:0] res_mem [MAX_LEN];
   logic [BW-1:0] src_q;
   logic [BW-1:0] res_q;

   logic                  req_fire;
   logic                  load_wr;
   logic                  walk_start;
   logic                  emit_rd;
   rfc_pkg::walk_ctl_type walk_ctl;
   logic [AW-1:0]         walk_rd_addr;
   logic [AW-1:0]         walk_wr_addr;

   rfc_walk #(
      .MAX_LEN (MAX_LEN)
   ) u_walk (
      .clock        (clock),
      .reset        (reset),
      .start        (walk_start),
      .rail_count   (rail_count_ff),
      .decrypt_mode (decrypt_ff),
      .msg_len      (count_ff),
      .walk_ctl     (walk_ctl),
      .rd_addr      (walk_rd_addr),
      .wr_addr      (walk_wr_addr)
   );

   // message buffer and result buffer
   always_ff @(posedge clock) begin
      if (load_wr) begin
         msg_mem[count_ff[AW-1:0]] <= req_tdata;
      end
      src_q <= msg_mem[walk_rd_addr];
      if (wr_en_ff) begin
         res_mem[wr_addr_ff] <= src_q;
      end
      res_q <= res_mem[emit_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rfc_pkg::ST_LOAD;
         rail_count_ff <= rfc_pkg::RAIL_RESET;
         decrypt_ff    <= 1'b0;
         count_ff      <= '0;
         ovf_ff        <= 1'b0;
         pend_ff       <= 1'b0;
         wr_en_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rail_count_ff <= rail_count_in;
         decrypt_ff    <= decrypt_in;
         count_ff      <= count_in;
         ovf_ff        <= ovf_in;
         pend_ff       <= pend_in;
         wr_en_ff      <= walk_ctl.issue;
         rsp_valid_ff  <= rsp_valid_in;
      end
      emit_ff      <= emit_in;
      pend_last_ff <= pend_last_in;
      wr_addr_ff   <= walk_wr_addr;
      rsp_data_ff  <= rsp_data_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   always_comb begin
      csr_ready     = 1'b1;
      rail_count_in = rail_count_ff;
      decrypt_in    = decrypt_ff;
      if (csr_valid) begin
         unique case (csr_index)
            rfc_pkg::CSR_RAIL_COUNT:   rail_count_in = csr_data;
            rfc_pkg::CSR_DECRYPT_MODE: decrypt_in    = csr_data[0];
            default:                   rail_count_in = rail_count_ff;
         endcase
      end
   end

   always_comb begin
      req_tready = (state_ff == rfc_pkg::ST_LOAD);
      req_fire   = req_tvalid && req_tready;
      load_wr    = req_fire && (count_ff < CW'(MAX_LEN));

      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      emit_in      = emit_ff;
      pend_in      = 1'b0;
      pend_last_in = pend_last_ff;
      walk_start   = 1'b0;
      emit_rd      = 1'b0;

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      unique case (state_ff)
         rfc_pkg::ST_LOAD: begin
            if (req_fire) begin
               if (load_wr) begin
                  count_in = count_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_tlast) begin
                  walk_start = 1'b1;
                  state_in   = rfc_pkg::ST_WALK;
               end
            end
         end
         rfc_pkg::ST_WALK: begin
            emit_in = '0;
            // the walk ends on a non-issue cycle, so its final write lands first
            if (walk_ctl.done) begin
               state_in = rfc_pkg::ST_EMIT;
            end
         end
         rfc_pkg::ST_EMIT: begin
            emit_rd = !pend_ff && (emit_ff < count_ff) && (!rsp_valid_ff || rsp_tready);
            if (emit_rd) begin
               pend_in      = 1'b1;
               pend_last_in = ((emit_ff + CW'(1)) == count_ff);
               emit_in      = emit_ff + CW'(1);
            end
            if (pend_ff) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_q;
               rsp_last_in  = pend_last_ff;
               rsp_ovf_in   = ovf_ff;
               if (pend_last_ff) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  state_in = rfc_pkg::ST_LOAD;
               end
            end
         end
         default: state_in = rfc_pkg::ST_LOAD;
      endcase

      rsp_tvalid = rsp_valid_ff;
      rsp_tdata  = rsp_data_ff;
      rsp_tlast  = rsp_last_ff;
      rsp_tuser  = rsp_ovf_ff;
   end

   // a fetched result only lands in an empty output register
   a_pend_slot_free: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> !rsp_valid_ff)
      else $error("result fetch collided with a held response");

   a_issue_in_walk: assert property (@(posedge clock) disable iff (reset)
      walk_ctl.issue |-> (state_ff == rfc_pkg::ST_WALK))
      else $error("walk issued a read outside the walk phase");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_LEN))
      else $error("byte count passed the buffer size");

   a_last_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tlast) |=> !req_tready)
      else $error("request accepted right after a last byte");

   a_emit_bound: assert property (@(posedge clock) disable iff (reset)
      emit_rd |-> (emit_ff < count_ff))
      else $error("result read past the message length");

endmodule : rail_fence_cipher
`default_nettype wire
